// File: rtl/i2cmbe_pkg.sv
`default_nettype none
package i2cmbe_pkg;

   // Command codes; codes above OP_READ decode as OP_IDLE
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned BITCNT_W   = 4;

   localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

   // Register indexes
   localparam logic [0:0] REG_DELAY_CYCLES = 1'b0;

   // Bus phase codes within a command
   localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
   localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
   localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
   localparam logic [PHASE_W-1:0] PH_3 = 3'd3;
   localparam logic [PHASE_W-1:0] PH_4 = 3'd4;

   // One classified tick word as it travels through the queue
   typedef struct packed {
      op_type     cmd;
      logic [7:0] tx_byte;
      logic       rd_ack;
      logic       sda_in;
   } tick_item_type;

   // Queue status toward the back end
   typedef struct packed {
      logic valid;
      logic full;
   } queue_stat_type;

endpackage
`default_nettype wire

// File: rtl/i2cmbe_front.sv
`default_nettype none
module i2cmbe_front
   import i2cmbe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [2:0]            req_tuser,
   input  wire logic                  queue_full,
   output logic                       push,
   output tick_item_type              item
);

   logic unused_ok;

   // Accept a word whenever the queue has room
   assign req_tready = ~queue_full;
   assign push       = req_tvalid & req_tready;

   // Classify the command; unknown codes become a plain tick
   always_comb begin
      item.tx_byte = req_tdata[7:0];
      item.rd_ack  = req_tdata[8];
      item.sda_in  = req_tdata[9];
      case (req_tuser)
         OP_START: item.cmd = OP_START;
         OP_STOP:  item.cmd = OP_STOP;
         OP_WRITE: item.cmd = OP_WRITE;
         OP_READ:  item.cmd = OP_READ;
         default:  item.cmd = OP_IDLE;
      endcase
   end

   assign unused_ok = &{1'b0, clock, reset, req_tdata[REQ_DATA_W-1:10]};

endmodule
`default_nettype wire

// File: rtl/i2cmbe_queue.sv
`default_nettype none
module i2cmbe_queue
   import i2cmbe_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  tick_item_type push_item,
   input  wire logic     pop,
   output tick_item_type pop_item,
   output queue_stat_type stat,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH-1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   tick_item_type    mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign pop_item   = mem[rd_ptr_ff];
   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == CNT_FULL);
   assign level      = count_ff;

endmodule
`default_nettype wire

// File: rtl/i2cmbe_back.sv
`default_nettype none
module i2cmbe_back
   import i2cmbe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            delay_cycles,
   input  queue_stat_type             qstat,
   input  tick_item_type              item,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   op_type               op_ff, op_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [BITCNT_W-1:0]  bits_ff, bits_in;
   logic [7:0]           shift_ff, shift_in;
   logic [7:0]           tick_ff, tick_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 ackf_ff, ackf_in;
   logic                 ackc_ff, ackc_in;
   logic [7:0]           rx_ff, rx_in;
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic                 done;
   logic [7:0]           delay_eff;
   logic [7:0]           tick_dec;
   logic [BITCNT_W-1:0]  bits_inc;

   // Take a word when the output register is free or being drained
   assign pop       = qstat.valid & (~out_valid_ff | rsp_tready);
   assign delay_eff = (delay_cycles == 8'd0) ? 8'd1 : delay_cycles;
   assign tick_dec  = (tick_ff != 8'd0) ? tick_ff - 8'd1 : 8'd0;
   assign bits_inc  = bits_ff + 1'b1;

   // Next engine state for one tick
   always_comb begin
      op_in    = op_ff;
      phase_in = phase_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ackf_in  = ackf_ff;
      ackc_in  = ackc_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      if (pop) begin
         if (op_ff == OP_IDLE) begin
            if (item.cmd != OP_IDLE) begin
               op_in    = item.cmd;
               bits_in  = '0;
               phase_in = PH_0;
               tick_in  = delay_eff;
               case (item.cmd)
                  OP_START: begin
                     sda_in = 1'b1;
                     scl_in = 1'b1;
                  end
                  OP_STOP: begin
                     sda_in = 1'b0;
                  end
                  OP_WRITE: begin
                     shift_in = item.tx_byte;
                     sda_in   = item.tx_byte[7];
                  end
                  OP_READ: begin
                     shift_in = '0;
                     ackc_in  = item.rd_ack;
                     sda_in   = 1'b1;
                     scl_in   = 1'b1;
                  end
                  default: begin
                     op_in = OP_IDLE;
                  end
               endcase
            end
         end else begin
            tick_in = tick_dec;
            if (tick_dec == 8'd0) begin
               // Phase boundary: apply the next phase or finish
               tick_in = delay_eff;
               case (op_ff)
                  OP_START: begin
                     if (phase_ff == PH_0) begin
                        sda_in   = 1'b0;
                        phase_in = PH_1;
                     end else begin
                        scl_in = 1'b0;
                        done   = 1'b1;
                     end
                  end
                  OP_STOP: begin
                     if (phase_ff == PH_0) begin
                        scl_in   = 1'b1;
                        phase_in = PH_1;
                     end else if (phase_ff == PH_1) begin
                        sda_in   = 1'b1;
                        phase_in = PH_2;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_WRITE: begin
                     if (phase_ff == PH_0) begin
                        scl_in   = 1'b1;
                        phase_in = PH_1;
                     end else if (phase_ff == PH_1) begin
                        scl_in   = 1'b0;
                        shift_in = {shift_ff[6:0], 1'b0};
                        bits_in  = bits_inc;
                        if (bits_inc < BITS_PER_BYTE) begin
                           sda_in   = shift_ff[6];
                           phase_in = PH_0;
                        end else begin
                           sda_in   = 1'b1;
                           phase_in = PH_2;
                        end
                     end else if (phase_ff == PH_2) begin
                        scl_in   = 1'b1;
                        phase_in = PH_3;
                     end else if (phase_ff == PH_3) begin
                        ackf_in  = ~item.sda_in;
                        scl_in   = 1'b0;
                        phase_in = PH_4;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (phase_ff == PH_0) begin
                        shift_in = {shift_ff[6:0], item.sda_in};
                        scl_in   = 1'b0;
                        phase_in = PH_1;
                     end else if (phase_ff == PH_1) begin
                        bits_in = bits_inc;
                        if (bits_inc < BITS_PER_BYTE) begin
                           scl_in   = 1'b1;
                           phase_in = PH_0;
                        end else begin
                           sda_in   = ~ackc_ff;
                           phase_in = PH_2;
                        end
                     end else if (phase_ff == PH_2) begin
                        scl_in   = 1'b1;
                        phase_in = PH_3;
                     end else if (phase_ff == PH_3) begin
                        scl_in   = 1'b0;
                        phase_in = PH_4;
                     end else begin
                        rx_in = shift_ff;
                        done  = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b0;
                  end
               endcase
               // Drop back to idle at the end of a command
               if (done || op_ff == OP_IDLE || op_ff > OP_READ) begin
                  op_in    = OP_IDLE;
                  phase_in = PH_0;
                  tick_in  = 8'd0;
               end
            end
         end
      end
   end

   // Build the result word and hold it until taken
   always_comb begin
      out_data_in     = '0;
      out_data_in[0]  = scl_in;
      out_data_in[1]  = sda_in;
      out_data_in[2]  = (op_in != OP_IDLE);
      out_data_in[3]  = done;
      out_data_in[11:4] = rx_in;
      out_data_in[12] = ackf_in;
      out_valid_in    = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_IDLE;
         phase_ff     <= PH_0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         tick_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ackf_ff      <= 1'b0;
         ackc_ff      <= 1'b0;
         rx_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         tick_ff      <= tick_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         ackf_ff      <= ackf_in;
         ackc_ff      <= ackc_in;
         rx_ff        <= rx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

// File: rtl/i2c_master_bit_engine.sv
// A word passes from the accepting edge through the queue, then the result register, to the
// earliest rsp handshake. Both rates below hold only while rsp_tready is high.
// Throughput: 1 word per cycle; the back-end engine retires one tick per cycle.
// Bus phase length is set by delay_cycles in ticks (zero acts as one).
// Reset (synchronous, active high): engine idle, SCL and SDA released, queue empty,
// delay_cycles = 8.
`default_nettype none
module i2c_master_bit_engine
   import i2cmbe_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: tx_byte[7:0], rd_ack[8], sda_in[9], zero[15:10]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: command[2:0]
   input  wire logic [2:0]            req_tuser,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
   //        ack_received[12], zero[15:13]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [7:0]     delay_ff, delay_in;
   logic           csr_wr;
   logic           push;
   logic           pop;
   tick_item_type  front_item;
   tick_item_type  back_item;
   queue_stat_type qstat;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] qlevel;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      delay_in = delay_ff;
      if (csr_wr && csr_paddr[2] == REG_DELAY_CYCLES) begin
         delay_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= 8'd8;
      end else begin
         delay_ff <= delay_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DELAY_CYCLES) ? {24'd0, delay_ff} : '0;

   i2cmbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (qstat.full),
      .push       (push),
      .item       (front_item)
   );

   i2cmbe_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (back_item),
      .stat      (qstat),
      .level     (qlevel)
   );

   i2cmbe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .delay_cycles (delay_ff),
      .qstat        (qstat),
      .item         (back_item),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   // A completed command never reports busy in the same word
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done with busy set");

   // Queue level never exceeds its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qlevel <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue overflow");

   // The engine only pops a word that the queue holds
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> qlevel != '0)
      else $error("pop from empty queue");

   // No result is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
`default_nettype wire
